// File: hdl/bbox_pkg.sv
// Shared widths, types, command codes and helpers for the bounding-box rasterizer.
package bbox_pkg;

	localparam int COORD_BITS = 11;
	localparam int DIFF_W     = COORD_BITS + 1;
	localparam int PROD_W     = 2 * DIFF_W;
	localparam int ACC_W      = PROD_W + 1;
	localparam int SUM_W      = ACC_W + 1;

	typedef logic [COORD_BITS-1:0]    coord_t;
	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [ACC_W-1:0]  acc_t;
	typedef logic signed [SUM_W-1:0]  sum_t;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_FETCH = 1'b1;

	function automatic coord_t min3(input coord_t a, input coord_t b, input coord_t c);
		coord_t m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

	function automatic coord_t max3(input coord_t a, input coord_t b, input coord_t c);
		coord_t m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	function automatic diff_t sub_coord(input coord_t a, input coord_t b);
		return diff_t'($signed({1'b0, a}) - $signed({1'b0, b}));
	endfunction

endpackage

// File: hdl/bbox_triangle_rasterizer_unit.sv
// Bounding-box triangle rasterizer: setup through a shared multiplier, then one pixel a cycle.
// Setup beat: load, edge prep, six products and a drain through the one multiplier, finish.
// Fetch beat: one bounding-box pixel tested per cycle until a hit
// or the box end, then the result is held in the output register until taken; no input is
// taken meanwhile. Walk uses incremental edge values: only adds and compares per pixel.
// Asynchronous active-low reset clears all state: no traversal, a fetch returns the end marker.
module bbox_triangle_rasterizer_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                command,
	input  bbox_pkg::coord_t    vertex0_x,
	input  bbox_pkg::coord_t    vertex0_y,
	input  bbox_pkg::coord_t    vertex1_x,
	input  bbox_pkg::coord_t    vertex1_y,
	input  bbox_pkg::coord_t    vertex2_x,
	input  bbox_pkg::coord_t    vertex2_y,
	output logic                out_valid,
	input  logic                out_stall,
	output bbox_pkg::coord_t    pixel_x,
	output bbox_pkg::coord_t    pixel_y,
	output logic                found
);
	import bbox_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_MUL,
		S_FIN,
		S_WALK,
		S_OUT
	} state_t;

	localparam logic [2:0] MUL_LAST = 3'd6;

	state_t     state_q;
	coord_t     vtx_q [6];
	coord_t     xmin_q, ymin_q, xmax_q, ymax_q;
	coord_t     cur_x_q, cur_y_q;
	diff_t      ex1_q, ey1_q, ex2_q, ey2_q, px0_q, py0_q;
	logic [2:0] mul_step_q;
	prod_t      prod_q;
	logic [2:0] prod_step_q;
	logic       prod_vld_q;
	acc_t       area_q, wu_q, wv_q, colu_q, colv_q;
	logic       active_q;
	logic       out_valid_q;
	coord_t     pix_x_q, pix_y_q;
	logic       found_q;

	diff_t  op_a, op_b;
	prod_t  prod_d;
	sum_t   w_sum, area_ext;
	logic   area_pos, area_neg, hit, last_pix;
	acc_t   acc_sel;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign pixel_x   = pix_x_q;
	assign pixel_y   = pix_y_q;
	assign found     = found_q;

	// shared multiplier operand select
	always_comb begin
		case (mul_step_q)
			3'd0: begin op_a = ex2_q; op_b = ey1_q; end
			3'd1: begin op_a = ex1_q; op_b = ey2_q; end
			3'd2: begin op_a = ex1_q; op_b = py0_q; end
			3'd3: begin op_a = px0_q; op_b = ey1_q; end
			3'd4: begin op_a = px0_q; op_b = ey2_q; end
			3'd5: begin op_a = ex2_q; op_b = py0_q; end
			default: begin op_a = '0; op_b = '0; end
		endcase
		prod_d = op_a * op_b;
	end

	// pick the accumulator the pending product belongs to
	always_comb begin
		case (prod_step_q[2:1])
			2'd0:    acc_sel = area_q;
			2'd1:    acc_sel = wu_q;
			default: acc_sel = wv_q;
		endcase
	end

	always_comb begin
		w_sum    = sum_t'(wu_q) + sum_t'(wv_q);
		area_ext = sum_t'(area_q);
		area_neg = area_q[ACC_W-1];
		area_pos = !area_neg && (area_q != '0);
		if (area_pos) begin
			hit = !wu_q[ACC_W-1] && !wv_q[ACC_W-1] && (w_sum <= area_ext);
		end else if (area_neg) begin
			hit = (wu_q <= 0) && (wv_q <= 0) && (w_sum >= area_ext);
		end else begin
			hit = 1'b0;
		end
		last_pix = (cur_y_q >= ymax_q) && (cur_x_q >= xmax_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			vtx_q       <= '{default: '0};
			xmin_q      <= '0;
			ymin_q      <= '0;
			xmax_q      <= '0;
			ymax_q      <= '0;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			ex1_q       <= '0;
			ey1_q       <= '0;
			ex2_q       <= '0;
			ey2_q       <= '0;
			px0_q       <= '0;
			py0_q       <= '0;
			prod_q      <= '0;
			prod_step_q <= '0;
			area_q      <= '0;
			wu_q        <= '0;
			wv_q        <= '0;
			colu_q      <= '0;
			colv_q      <= '0;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
			prod_vld_q  <= 1'b0;
			mul_step_q  <= '0;
			found_q     <= 1'b0;
			pix_x_q     <= '0;
			pix_y_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (command == CMD_LOAD) begin
							vtx_q[0] <= vertex0_x;
							vtx_q[1] <= vertex0_y;
							vtx_q[2] <= vertex1_x;
							vtx_q[3] <= vertex1_y;
							vtx_q[4] <= vertex2_x;
							vtx_q[5] <= vertex2_y;
							xmin_q   <= min3(vertex0_x, vertex1_x, vertex2_x);
							ymin_q   <= min3(vertex0_y, vertex1_y, vertex2_y);
							xmax_q   <= max3(vertex0_x, vertex1_x, vertex2_x);
							ymax_q   <= max3(vertex0_y, vertex1_y, vertex2_y);
							cur_x_q  <= min3(vertex0_x, vertex1_x, vertex2_x);
							cur_y_q  <= min3(vertex0_y, vertex1_y, vertex2_y);
							active_q <= 1'b0;
							state_q  <= S_PREP;
						end else if (active_q) begin
							state_q <= S_WALK;
						end else begin
							pix_x_q     <= '0;
							pix_y_q     <= '0;
							found_q     <= 1'b0;
							out_valid_q <= 1'b1;
							state_q     <= S_OUT;
						end
					end
				end
				S_PREP: begin
					ex1_q      <= sub_coord(vtx_q[2], vtx_q[0]);
					ey1_q      <= sub_coord(vtx_q[3], vtx_q[1]);
					ex2_q      <= sub_coord(vtx_q[4], vtx_q[0]);
					ey2_q      <= sub_coord(vtx_q[5], vtx_q[1]);
					px0_q      <= sub_coord(vtx_q[0], xmin_q);
					py0_q      <= sub_coord(vtx_q[1], ymin_q);
					area_q     <= '0;
					wu_q       <= '0;
					wv_q       <= '0;
					mul_step_q <= '0;
					prod_vld_q <= 1'b0;
					state_q    <= S_MUL;
				end
				S_MUL: begin
					prod_q      <= prod_d;
					prod_step_q <= mul_step_q;
					prod_vld_q  <= (mul_step_q != MUL_LAST);
					// even steps add, odd steps subtract
					if (prod_vld_q) begin
						case (prod_step_q[2:1])
							2'd0: area_q <= prod_step_q[0] ? acc_sel - acc_t'(prod_q)
								: acc_sel + acc_t'(prod_q);
							2'd1: wu_q <= prod_step_q[0] ? acc_sel - acc_t'(prod_q)
								: acc_sel + acc_t'(prod_q);
							default: wv_q <= prod_step_q[0] ? acc_sel - acc_t'(prod_q)
								: acc_sel + acc_t'(prod_q);
						endcase
					end
					if (mul_step_q == MUL_LAST) begin
						state_q <= S_FIN;
					end else begin
						mul_step_q <= mul_step_q + 3'd1;
					end
				end
				S_FIN: begin
					colu_q   <= wu_q;
					colv_q   <= wv_q;
					active_q <= (area_q != '0);
					state_q  <= S_IDLE;
				end
				S_WALK: begin
					// advance the cursor, y inner, x outer
					if (cur_y_q < ymax_q) begin
						cur_y_q <= cur_y_q + coord_t'(1);
						wu_q    <= wu_q - acc_t'(ex1_q);
						wv_q    <= wv_q + acc_t'(ex2_q);
					end else if (cur_x_q < xmax_q) begin
						cur_y_q <= ymin_q;
						cur_x_q <= cur_x_q + coord_t'(1);
						colu_q  <= colu_q + acc_t'(ey1_q);
						colv_q  <= colv_q - acc_t'(ey2_q);
						wu_q    <= colu_q + acc_t'(ey1_q);
						wv_q    <= colv_q - acc_t'(ey2_q);
					end else begin
						active_q <= 1'b0;
					end
					if (hit) begin
						pix_x_q     <= cur_x_q;
						pix_y_q     <= cur_y_q;
						found_q     <= 1'b1;
						out_valid_q <= 1'b1;
						state_q     <= S_OUT;
					end else if (last_pix) begin
						pix_x_q     <= '0;
						pix_y_q     <= '0;
						found_q     <= 1'b0;
						out_valid_q <= 1'b1;
						state_q     <= S_OUT;
					end
				end
				S_OUT: begin
					// hold the result beat until taken
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
